### sv/tse_pkg.sv
`timescale 1ns / 1ps
// Package for the Taylor series exp / log unit: widths, codes, lane types
// and the term sign rule. No dependencies.
package tse_pkg;

    localparam int TERMS_DEF     = 100;
    localparam int FRAC_BITS_DEF = 32;

    localparam int ARG_W    = 32;
    localparam int ARG_FRAC = 28;
    localparam int VAL_W    = 48;
    localparam int ST_W     = 2;
    localparam int OP_W     = 2;
    localparam int MAG_W    = 4;

    localparam int C_W      = 57;
    localparam int ACC_W    = 64;
    localparam int IDX_W    = 7;
    localparam int CHUNK_W  = 19;
    localparam int N_CHUNKS = C_W / CHUNK_W;
    localparam int V_W      = IDX_W + CHUNK_W;
    localparam int RECIP_W  = V_W + 1;

    localparam logic [C_W-1:0] POW_CAP = C_W'(1) << 56;
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_EXP  = 2'd0,
        OP_LN1P = 2'd1,
        OP_LN1M = 2'd2
    } op_t;

    localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_DOMAIN = 2'd1,
        ST_OVF    = 2'd2
    } status_t;

    typedef struct packed {
        op_t              op;
        logic             xneg;
        logic             err;
        logic             cap;
        logic [ARG_W-1:0] fac;
    } ctl_t;

    typedef struct packed {
        ctl_t                     ctl;
        logic [C_W-1:0]           c;
        logic signed [ACC_W-1:0]  acc;
    } lane_t;

    function automatic logic term_neg(op_t op, logic xneg, logic odd);
        logic pneg;
        pneg = xneg & odd;
        if (op == OP_EXP)
            return pneg;
        else if (op == OP_LN1P)
            return pneg ^ ~odd;
        else
            return ~pneg;
    endfunction

endpackage

### sv/tse_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the Taylor series unit: argument beats in,
// result beats out. Depends on nothing.
interface tse_arg_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] argument;

    modport source (output valid, operation, argument, input ready);
    modport sink   (input valid, operation, argument, output ready);
endinterface

interface tse_res_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] value;
    logic [1:0]         status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

### sv/taylor_series_exp_log.sv
`timescale 1ns / 1ps
// Top level of the Taylor series exp / ln(1+x) / ln(1-x) unit.
// Depends on tse_pkg, tse_chan_if, tse_front, tse_cell and tse_back.
//
//  channel   dir   payload                            handshake
//  arg_ch    in    operation[1:0], argument[31:0]     valid / ready
//  res_ch    out   value[47:0], status[1:0]           valid / ready
//
// One beat accepted per cycle while the result is not stalled; each beat
// passes tse_front, the chain of term cells, nine stages each, and tse_back.
// Reset clears only the valid bits of every stage.
// A stalled result freezes the whole pipeline; arg_ch.ready is low only
// while res_ch holds a result that is not taken.
module taylor_series_exp_log #(
    parameter int TERMS     = tse_pkg::TERMS_DEF,
    parameter int FRAC_BITS = tse_pkg::FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tse_arg_if.sink   arg_ch,
    tse_res_if.source res_ch
);
    import tse_pkg::*;

    logic             en;
    lane_t            lane_w [TERMS];
    logic [TERMS-1:0] lane_valid;

    assign en = ~res_ch.valid | res_ch.ready;

    tse_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .arg_ch    (arg_ch),
        .out_valid (lane_valid[0]),
        .out_lane  (lane_w[0])
    );

    for (genvar g = 1; g < TERMS; g++) begin : g_term
        tse_cell #(
            .IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (lane_valid[g-1]),
            .in_lane   (lane_w[g-1]),
            .out_valid (lane_valid[g]),
            .out_lane  (lane_w[g])
        );
    end

    tse_back #(
        .TERMS (TERMS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (lane_valid[TERMS-1]),
        .in_lane  (lane_w[TERMS-1]),
        .res_ch   (res_ch)
    );

endmodule

### sv/tse_front.sv
`timescale 1ns / 1ps
// Entry stage: decodes the operation, checks the domain and sets up the
// first power and the sum. Depends on tse_pkg and tse_arg_if.
module tse_front #(
    parameter int FRAC_BITS = tse_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    tse_arg_if.sink        arg_ch,
    output logic           out_valid,
    output tse_pkg::lane_t out_lane
);
    import tse_pkg::*;

    localparam logic signed [ARG_W-1:0] ARG_ONE = ARG_W'(1) << ARG_FRAC;

    logic               valid_reg;
    lane_t              lane_reg;
    lane_t              lane_next;
    logic signed [ARG_W-1:0] x;
    logic signed [MAG_W-1:0] n;
    logic [MAG_W-1:0]   mag;
    logic [ARG_W-1:0]   a;
    logic [C_W-1:0]     m1;
    logic               below;
    logic               above;

    assign arg_ch.ready = en;

    assign x     = arg_ch.argument;
    assign n     = x[ARG_W-1 -: MAG_W];
    assign mag   = n[MAG_W-1] ? MAG_W'(0 - n) : MAG_W'(n);
    assign a     = x[ARG_W-1] ? ARG_W'(0 - x) : ARG_W'(x);
    assign below = x <= -ARG_ONE;
    assign above = x >= ARG_ONE;

    if (FRAC_BITS >= ARG_FRAC) begin : g_up
        assign m1 = C_W'(a) << (FRAC_BITS - ARG_FRAC);
    end else begin : g_down
        assign m1 = C_W'(a) >> (ARG_FRAC - FRAC_BITS);
    end

    always_comb
    begin
        lane_next          = '0;
        lane_next.ctl.xneg = x[ARG_W-1];
        lane_next.ctl.cap  = 1'b0;
        unique case (arg_ch.operation)
            OP_EXP:
            begin
                lane_next.ctl.op  = OP_EXP;
                lane_next.ctl.err = |x[ARG_FRAC-1:0];
                lane_next.ctl.fac = ARG_W'(mag);
                lane_next.c       = C_W'(1) << FRAC_BITS;
                lane_next.acc     = ACC_W'(1) << FRAC_BITS;
            end
            OP_LN1P:
            begin
                lane_next.ctl.op  = OP_LN1P;
                lane_next.ctl.err = below;
                lane_next.ctl.fac = a;
                lane_next.c       = m1;
            end
            OP_LN1M:
            begin
                lane_next.ctl.op  = OP_LN1M;
                lane_next.ctl.err = below | above;
                lane_next.ctl.fac = a;
                lane_next.c       = m1;
            end
            default:
            begin
                lane_next.ctl.op  = OP_LN1M;
                lane_next.ctl.err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= arg_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

### sv/tse_cell.sv
`timescale 1ns / 1ps
// One series term: power multiply, chunked division by the term index and
// signed accumulation, nine register stages. Depends on tse_pkg.
module tse_cell #(
    parameter int IDX = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  tse_pkg::lane_t in_lane,
    output logic           out_valid,
    output tse_pkg::lane_t out_lane
);
    import tse_pkg::*;

    localparam logic [IDX_W-1:0]   DIV    = IDX_W'(IDX);
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((64'd1 << V_W) / IDX);
    localparam logic               ODD    = (IDX % 2) == 1;
    localparam bit                 FIRST  = IDX == 1;
    localparam int HI_W   = C_W - ARG_W;
    localparam int HP_W   = HI_W + ARG_W;
    localparam int LO_W   = 2 * ARG_W;
    localparam int SUM_W  = C_W + ARG_W;
    localparam int PW     = SUM_W - ARG_FRAC;
    localparam int PROD_W = V_W + RECIP_W;
    localparam int QE_W   = CHUNK_W + 1;
    localparam int RW     = QE_W + IDX_W;

    typedef struct packed {
        ctl_t                    ctl;
        logic signed [ACC_W-1:0] acc;
        logic [C_W-1:0]          p;
        logic [C_W-1:0]          q;
        logic [IDX_W-1:0]        r;
    } dv_t;

    // multiply
    logic              s1_valid_reg;
    lane_t             s1_lane_reg;
    logic [LO_W-1:0]   s1_lo_reg, s1_lo_next;
    logic [HP_W-1:0]   s1_hi_reg, s1_hi_next;

    assign s1_lo_next = {ARG_W'(0), in_lane.c[ARG_W-1:0]} * {ARG_W'(0), in_lane.ctl.fac};
    assign s1_hi_next = {ARG_W'(0), in_lane.c[C_W-1:ARG_W]} * {HI_W'(0), in_lane.ctl.fac};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_lane_reg <= in_lane;
            s1_lo_reg   <= s1_lo_next;
            s1_hi_reg   <= s1_hi_next;
        end
    end

    // combine and check the power cap
    logic              s2_valid_reg;
    dv_t               s2_dv_reg, s2_dv_next;
    logic [SUM_W-1:0]  s2_sum;
    logic [PW-1:0]     s2_p;
    logic              s2_is_exp;

    assign s2_sum    = {s1_hi_reg, ARG_W'(0)} + SUM_W'(s1_lo_reg);
    assign s2_is_exp = s1_lane_reg.ctl.op == OP_EXP;

    always_comb
    begin
        if (s2_is_exp)
            s2_p = s2_sum[PW-1:0];
        else if (FIRST)
            s2_p = PW'(s1_lane_reg.c);
        else
            s2_p = s2_sum[SUM_W-1:ARG_FRAC];
        s2_dv_next         = '0;
        s2_dv_next.ctl     = s1_lane_reg.ctl;
        s2_dv_next.ctl.cap = s1_lane_reg.ctl.cap | (~s2_is_exp & (s2_p > PW'(POW_CAP)));
        s2_dv_next.acc     = s1_lane_reg.acc;
        s2_dv_next.p       = s2_p[C_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s2_dv_reg <= s2_dv_next;
    end

    // divide by the term index, one chunk per two stages
    dv_t                 ch_in [N_CHUNKS];
    logic [N_CHUNKS-1:0] ch_in_valid;
    dv_t                 da_reg [N_CHUNKS];
    dv_t                 db_reg [N_CHUNKS];
    logic [V_W-1:0]      va_reg [N_CHUNKS];
    logic [PROD_W-1:0]   pa_reg [N_CHUNKS];
    logic [N_CHUNKS-1:0] da_valid_reg;
    logic [N_CHUNKS-1:0] db_valid_reg;

    for (genvar k = 0; k < N_CHUNKS; k++) begin : g_chunk
        logic [V_W-1:0]    v_next;
        logic [PROD_W-1:0] prod_next;
        logic [QE_W-1:0]   q_est;
        logic [RW-1:0]     rem;
        logic [QE_W-1:0]   q_fix;
        logic [RW-1:0]     rem_fix;
        dv_t               db_next;

        if (k == 0) begin : g_src0
            assign ch_in[k]       = s2_dv_reg;
            assign ch_in_valid[k] = s2_valid_reg;
        end else begin : g_srcn
            assign ch_in[k]       = db_reg[k-1];
            assign ch_in_valid[k] = db_valid_reg[k-1];
        end

        assign v_next    = {ch_in[k].r, ch_in[k].p[C_W-1-k*CHUNK_W -: CHUNK_W]};
        assign prod_next = {RECIP_W'(0), v_next} * {V_W'(0), RECIP};

        assign q_est = pa_reg[k][V_W+QE_W-1:V_W];
        assign rem   = RW'(va_reg[k]) - ({IDX_W'(0), q_est} * {QE_W'(0), DIV});

        always_comb
        begin
            if (rem >= RW'(DIV))
            begin
                q_fix   = q_est + QE_W'(1);
                rem_fix = rem - RW'(DIV);
            end
            else
            begin
                q_fix   = q_est;
                rem_fix = rem;
            end
            db_next   = da_reg[k];
            db_next.q = {da_reg[k].q[C_W-CHUNK_W-1:0], q_fix[CHUNK_W-1:0]};
            db_next.r = rem_fix[IDX_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                da_valid_reg[k] <= 1'b0;
                db_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                da_valid_reg[k] <= ch_in_valid[k];
                db_valid_reg[k] <= da_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                da_reg[k] <= ch_in[k];
                va_reg[k] <= v_next;
                pa_reg[k] <= prod_next;
                db_reg[k] <= db_next;
            end
        end
    end

    // accumulate the signed term
    logic                    fin_valid_reg;
    lane_t                   fin_lane_reg, fin_lane_next;
    dv_t                     last;
    logic signed [ACC_W-1:0] term;

    assign last = db_reg[N_CHUNKS-1];
    assign term = ACC_W'(last.q);

    always_comb
    begin
        fin_lane_next     = '0;
        fin_lane_next.ctl = last.ctl;
        fin_lane_next.c   = (last.ctl.op == OP_EXP) ? last.q : last.p;
        if (term_neg(last.ctl.op, last.ctl.xneg, ODD))
            fin_lane_next.acc = last.acc - term;
        else
            fin_lane_next.acc = last.acc + term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (en)
            fin_valid_reg <= db_valid_reg[N_CHUNKS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fin_lane_reg <= fin_lane_next;
    end

    assign out_valid = fin_valid_reg;
    assign out_lane  = fin_lane_reg;

endmodule

### sv/tse_back.sv
`timescale 1ns / 1ps
// Result stage: domain errors, power cap and 48-bit saturation into the
// output register. Depends on tse_pkg and tse_res_if.
module tse_back #(
    parameter int TERMS = tse_pkg::TERMS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  tse_pkg::lane_t in_lane,
    tse_res_if.source      res_ch
);
    import tse_pkg::*;

    localparam logic LAST_ODD = ((TERMS - 1) % 2) == 1;

    logic                    valid_reg;
    logic signed [VAL_W-1:0] value_reg, value_next;
    status_t                 status_reg, status_next;
    logic [ACC_W-VAL_W:0]    top_bits;
    logic                    fits;

    assign top_bits = in_lane.acc[ACC_W-1:VAL_W-1];
    assign fits     = (&top_bits) | ~(|top_bits);

    always_comb
    begin
        if (in_lane.ctl.err)
        begin
            value_next  = '0;
            status_next = ST_DOMAIN;
        end
        else if (in_lane.ctl.cap)
        begin
            value_next  = term_neg(in_lane.ctl.op, in_lane.ctl.xneg, LAST_ODD) ? VAL_MIN : VAL_MAX;
            status_next = ST_OVF;
        end
        else if (!fits)
        begin
            value_next  = in_lane.acc[ACC_W-1] ? VAL_MIN : VAL_MAX;
            status_next = ST_OVF;
        end
        else
        begin
            value_next  = in_lane.acc[VAL_W-1:0];
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign res_ch.valid  = valid_reg;
    assign res_ch.value  = value_reg;
    assign res_ch.status = status_reg;

endmodule

### sv/tse_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the Taylor series unit, bound to the top level.
// Depends on tse_pkg.
module tse_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               arg_valid,
    input logic               arg_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic signed [47:0] value,
    input logic [1:0]         status
);
    import tse_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status == ST_OK || status == ST_DOMAIN || status == ST_OVF))
        else $error("result status code out of range");

    a_domain_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_DOMAIN |-> value == '0)
        else $error("domain error with nonzero value");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_OVF |-> (value == VAL_MAX || value == VAL_MIN))
        else $error("overflow without saturated value");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !arg_ready |-> res_valid && !res_ready)
        else $error("argument stalled without result stall");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(value) && $stable(status))
        else $error("stalled result beat changed");

endmodule

bind taylor_series_exp_log tse_checker u_tse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .arg_valid (arg_ch.valid),
    .arg_ready (arg_ch.ready),
    .res_valid (res_ch.valid),
    .res_ready (res_ch.ready),
    .value     (res_ch.value),
    .status    (res_ch.status)
);
